>>> hw/rtl/wsp_pkg.sv
// Shared types, codes and helpers of the waveform segment player.
package wsp_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 64;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;
  localparam logic [1:0] FUNC_STOP  = 2'd3;

  localparam logic [7:0] IDLE_CODE     = 8'd255;
  localparam logic [7:0] FREQ_MIN      = 8'd10;
  localparam logic [7:0] FREQ_MAX      = 8'd240;
  localparam logic [15:0] INTENSITY_MAX = 16'd100;

  localparam int unsigned SLOT_W = 20;

  typedef struct packed {
    logic [1:0]  func;
    logic        entry_first;
    logic [7:0]  entry_freq;
    logic [15:0] entry_intensity;
    logic [15:0] entry_repeat;
  } in_word_t;

  typedef struct packed {
    logic [7:0] freq_out;
    logic [7:0] intensity_out;
    logic       playing;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  freq;
    logic [6:0]  intensity;
    logic [15:0] repeat_cnt;
  } entry_t;

  typedef struct packed {
    logic load;
    logic start;
    logic stop;
    logic rd;
    logic emit_idle;
    logic emit_play;
  } ctrl_cmd_t;

  typedef struct packed {
    logic play_ok;
    logic out_busy;
  } ctrl_sts_t;

  // Ticks per repeat: ceil(duration/100) for a clamped frequency code.
  function automatic logic [3:0] tick_factor(input logic [7:0] freq);
    logic [3:0] f;
    if (freq <= 8'd100)      f = 4'd1;
    else if (freq <= 8'd120) f = 4'd2;
    else if (freq <= 8'd140) f = 4'd3;
    else if (freq <= 8'd160) f = 4'd4;
    else if (freq <= 8'd180) f = 4'd5;
    else if (freq <= 8'd200) f = 4'd6;
    else if (freq <= 8'd210) f = 4'd7;
    else if (freq <= 8'd220) f = 4'd8;
    else if (freq <= 8'd230) f = 4'd9;
    else                     f = 4'd10;
    return f;
  endfunction

endpackage

>>> hw/rtl/wsp_ctrl.sv
// Sequencing controller of the waveform segment player.
module wsp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         func_i,
  output logic               in_ready_o,
  input  wsp_pkg::ctrl_sts_t sts_i,
  output wsp_pkg::ctrl_cmd_t cmd_o
);
  import wsp_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPlay = 2'd1;
  localparam logic [1:0] StHold = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (func_i)
            FUNC_LOAD:  cmd_o.load  = 1'b1;
            FUNC_START: cmd_o.start = 1'b1;
            FUNC_STOP:  cmd_o.stop  = 1'b1;
            default: begin
              // tick: fetch the current entry, or report idle
              if (sts_i.play_ok) begin
                cmd_o.rd = 1'b1;
                state_d  = StPlay;
              end else begin
                state_d = StHold;
              end
            end
          endcase
        end
      end
      StPlay: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit_play = 1'b1;
          state_d         = StIdle;
        end
      end
      StHold: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit_idle = 1'b1;
          state_d         = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/wsp_dpath.sv
// Entry store, playback counters and output register of the waveform segment player.
module wsp_dpath #(
  parameter int unsigned TABLE_DEPTH = wsp_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wsp_pkg::in_word_t  in_data_i,
  input  wsp_pkg::ctrl_cmd_t cmd_i,
  output wsp_pkg::ctrl_sts_t sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wsp_pkg::out_word_t out_data_o
);
  import wsp_pkg::*;

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned LenW = $clog2(TABLE_DEPTH + 1);
  localparam logic [LenW-1:0] DepthLen = LenW'(TABLE_DEPTH);

  entry_t mem_q [TABLE_DEPTH];
  entry_t rd_q;

  logic [LenW-1:0]   len_q, len_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [SLOT_W-1:0] slots_q, slots_d;
  logic              run_q, run_d;
  out_word_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  entry_t          wr_entry;
  logic [IdxW-1:0] rd_idx;
  logic [SLOT_W-1:0] ticks, slots_cur, slots_dec;
  logic [LenW-1:0]   idx_inc;

  // Clamp fields of a loaded entry.
  always_comb begin
    if (in_data_i.entry_freq < FREQ_MIN)      wr_entry.freq = FREQ_MIN;
    else if (in_data_i.entry_freq > FREQ_MAX) wr_entry.freq = FREQ_MAX;
    else                                      wr_entry.freq = in_data_i.entry_freq;
    if (in_data_i.entry_intensity > INTENSITY_MAX) begin
      wr_entry.intensity = INTENSITY_MAX[6:0];
    end else begin
      wr_entry.intensity = in_data_i.entry_intensity[6:0];
    end
    wr_entry.repeat_cnt = (in_data_i.entry_repeat == 16'd0) ? 16'd1
                                                           : in_data_i.entry_repeat;
  end

  assign wr_idx = in_data_i.entry_first ? '0 : len_q[IdxW-1:0];
  assign wr_en  = cmd_i.load && (in_data_i.entry_first || (len_q < DepthLen));
  assign rd_idx = (LenW'(idx_q) >= len_q) ? '0 : idx_q;

  assign ticks     = SLOT_W'(tick_factor(rd_q.freq)) * SLOT_W'(rd_q.repeat_cnt);
  assign slots_cur = (slots_q == '0) ? ticks : slots_q;
  assign slots_dec = slots_cur - SLOT_W'(1);
  assign idx_inc   = LenW'(idx_q) + LenW'(1);

  always_comb begin
    len_d   = len_q;
    idx_d   = idx_q;
    slots_d = slots_q;
    run_d   = run_q;
    out_d   = out_q;
    if (cmd_i.load) begin
      if (in_data_i.entry_first) begin
        len_d   = LenW'(1);
        idx_d   = '0;
        slots_d = '0;
      end else if (len_q < DepthLen) begin
        len_d = len_q + LenW'(1);
      end
    end
    if (cmd_i.start && (len_q != '0) && !run_q) begin
      idx_d   = '0;
      slots_d = '0;
      run_d   = 1'b1;
    end
    if (cmd_i.stop) run_d = 1'b0;
    if (cmd_i.rd) idx_d = rd_idx;
    if (cmd_i.emit_idle) begin
      out_d.freq_out      = IDLE_CODE;
      out_d.intensity_out = IDLE_CODE;
      out_d.playing       = run_q;
    end
    if (cmd_i.emit_play) begin
      out_d.freq_out      = rd_q.freq;
      out_d.intensity_out = {1'b0, rd_q.intensity};
      out_d.playing       = run_q;
      slots_d             = slots_dec;
      // advance to the next entry once this one is used up
      if (slots_dec == '0) begin
        idx_d = (idx_inc >= len_q) ? '0 : idx_inc[IdxW-1:0];
      end
    end
  end

  assign out_valid_d = cmd_i.emit_idle || cmd_i.emit_play || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_idx] <= wr_entry;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rd_q <= mem_q[rd_idx];
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      idx_q       <= '0;
      slots_q     <= '0;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      idx_q       <= idx_d;
      slots_q     <= slots_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.play_ok  = run_q && (len_q != '0);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= DepthLen)
    else $error("table length beyond depth");

  a_run_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (len_q != '0))
    else $error("playback running on an empty table");

  a_idx_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != '0) |-> (LenW'(idx_q) < len_q))
    else $error("play index outside table");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_play || cmd_i.emit_idle) |-> !(out_valid_q && !out_ready_i))
    else $error("result written over an untaken word");

endmodule

>>> hw/rtl/waveform_segment_player_unit.sv
// Top level of the waveform segment player.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one command word:
// tick, load entry, start or stop. Loads append an entry to the table while it
// has room (a first marker empties it before storing); start restarts playback
// at entry 0 if the table holds entries and playback is stopped; stop halts it.
// Output channel (out_valid_o / out_ready_i / out_data_o) carries one word per
// tick: current frequency and intensity, or 255/255 while stopped.
// Load, start and stop take effect as they are accepted. A tick, while playing,
// makes a registered read of the entry store, then the count update and output
// register write; while stopped, it passes through a hold state, then the idle
// word is written. The word shows on the output the cycle after that, and the
// next input word is accepted from then on.
// If the receiver stalls, a tick waits in the controller until the output
// register is taken; no word is lost. Reset empties the table, stops playback
// and clears the output valid; entry contents are left as they were.
module waveform_segment_player_unit #(
  parameter int unsigned TABLE_DEPTH = wsp_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wsp_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wsp_pkg::out_word_t out_data_o
);
  import wsp_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  wsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (in_data_i.func),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wsp_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> dv/waveform_segment_player_unit_tb.sv
// Testbench of the waveform segment player: random and directed words against a predictor.
`timescale 1ns / 1ps

class player_scoreboard;
  localparam int unsigned DEPTH = wsp_pkg::DEFAULT_TABLE_DEPTH;

  logic [7:0]  tbl_freq   [DEPTH];
  logic [6:0]  tbl_level  [DEPTH];
  logic [15:0] tbl_repeat [DEPTH];
  int unsigned tbl_len;
  int unsigned play_pos;
  logic [19:0] ticks_left;
  bit          running;
  wsp_pkg::out_word_t expected_words[$];
  int unsigned errors;

  function new();
    tbl_len    = 0;
    play_pos   = 0;
    ticks_left = '0;
    running    = 1'b0;
    errors     = 0;
  endfunction

  // Ticks one entry lasts: ceil(duration/100) per repeat.
  function automatic logic [19:0] segment_ticks(logic [7:0] f, logic [15:0] rep);
    int unsigned code;
    int unsigned dur;
    code = f;
    if (code <= 100) dur = code;
    else if (code <= 200) dur = (code - 100) * 5 + 100;
    else dur = (code - 200) * 10 + 600;
    return 20'(((dur - 1) / 100 + 1) * rep);
  endfunction

  function void note_command(wsp_pkg::in_word_t w);
    wsp_pkg::out_word_t want;
    logic [7:0]  f;
    logic [15:0] z;
    logic [15:0] r;
    case (w.func)
      wsp_pkg::FUNC_LOAD: begin
        if (w.entry_first) begin
          tbl_len    = 0;
          play_pos   = 0;
          ticks_left = '0;
        end
        if (tbl_len < DEPTH) begin
          f = w.entry_freq;
          z = w.entry_intensity;
          r = w.entry_repeat;
          if (f < wsp_pkg::FREQ_MIN) f = wsp_pkg::FREQ_MIN;
          if (f > wsp_pkg::FREQ_MAX) f = wsp_pkg::FREQ_MAX;
          if (z > wsp_pkg::INTENSITY_MAX) z = wsp_pkg::INTENSITY_MAX;
          if (r == 16'd0) r = 16'd1;
          tbl_freq[tbl_len]   = f;
          tbl_level[tbl_len]  = z[6:0];
          tbl_repeat[tbl_len] = r;
          tbl_len++;
        end
      end
      wsp_pkg::FUNC_START: begin
        if (tbl_len != 0 && !running) begin
          play_pos   = 0;
          ticks_left = '0;
          running    = 1'b1;
        end
      end
      wsp_pkg::FUNC_STOP: begin
        running = 1'b0;
      end
      wsp_pkg::FUNC_TICK: begin
        want.freq_out      = wsp_pkg::IDLE_CODE;
        want.intensity_out = wsp_pkg::IDLE_CODE;
        want.playing       = running;
        if (running && tbl_len != 0) begin
          if (play_pos >= tbl_len) play_pos = 0;
          if (ticks_left == 0)
            ticks_left = segment_ticks(tbl_freq[play_pos], tbl_repeat[play_pos]);
          want.freq_out      = tbl_freq[play_pos];
          want.intensity_out = {1'b0, tbl_level[play_pos]};
          ticks_left--;
          if (ticks_left == 0) begin
            play_pos++;
            if (play_pos >= tbl_len) play_pos = 0;
          end
        end
        expected_words.insert(expected_words.size(), want);
      end
    endcase
  endfunction

  function void check_word(wsp_pkg::out_word_t got);
    wsp_pkg::out_word_t want;
    if (expected_words.size() == 0) begin
      errors++;
      $display("%0t: unexpected word: expected none, actual freq %0d intensity %0d playing %0b",
               $time, got.freq_out, got.intensity_out, got.playing);
      return;
    end
    want = expected_words.pop_front();
    if (got.freq_out !== want.freq_out) begin
      errors++;
      $display("%0t: freq_out expected %0d actual %0d", $time, want.freq_out, got.freq_out);
    end
    if (got.intensity_out !== want.intensity_out) begin
      errors++;
      $display("%0t: intensity_out expected %0d actual %0d",
               $time, want.intensity_out, got.intensity_out);
    end
    if (got.playing !== want.playing) begin
      errors++;
      $display("%0t: playing expected %0b actual %0b", $time, want.playing, got.playing);
    end
  endfunction
endclass

module waveform_segment_player_unit_tb;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  wsp_pkg::in_word_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  wsp_pkg::out_word_t out_data_o;

  player_scoreboard sb = new();
  int unsigned words_sent = 0;

  waveform_segment_player_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Random command word; payload bits are don't-care outside loads.
  function automatic wsp_pkg::in_word_t cmd_word(logic [1:0] func);
    logic [63:0] bits;
    wsp_pkg::in_word_t w;
    bits = {$urandom, $urandom};
    w = bits[$bits(wsp_pkg::in_word_t)-1:0];
    w.func = func;
    return w;
  endfunction

  function automatic wsp_pkg::in_word_t load_word(logic first, logic [7:0] f,
                                                  logic [15:0] z, logic [15:0] r);
    wsp_pkg::in_word_t w;
    w.func            = wsp_pkg::FUNC_LOAD;
    w.entry_first     = first;
    w.entry_freq      = f;
    w.entry_intensity = z;
    w.entry_repeat    = r;
    return w;
  endfunction

  function automatic wsp_pkg::in_word_t random_entry(logic first);
    logic [7:0]  f;
    logic [15:0] z;
    logic [15:0] r;
    f = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 130));
    z = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 120));
    r = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    return load_word(first, f, z, r);
  endfunction

  task automatic send_word(input wsp_pkg::in_word_t w);
    // no idling while the word count is inside the burst window
    while (!(words_sent >= 150 && words_sent < 260) && $urandom_range(0, 99) < 14) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(w);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_ticks(input int unsigned count);
    repeat (count) send_word(cmd_word(wsp_pkg::FUNC_TICK));
  endtask

  // Well-formed run: fresh table, start, ticks, optional stop.
  task automatic play_segment_run(input int unsigned loads, input int unsigned ticks,
                                  input bit halt);
    send_word(random_entry(1'b1));
    for (int unsigned i = 1; i < loads; i++) send_word(random_entry(1'b0));
    send_word(cmd_word(wsp_pkg::FUNC_START));
    send_ticks(ticks);
    if (halt) send_word(cmd_word(wsp_pkg::FUNC_STOP));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_word(out_data_o);
  end

  // Receiver: random stalls, one long hold-off to back up the block, one stall-free stretch.
  initial begin
    int unsigned cyc;
    out_ready_i = 1'b0;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc >= 500 && cyc < 750) out_ready_i <= 1'b0;
      else if (cyc >= 900 && cyc < 1300) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 99) >= 14);
    end
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    in_valid_i = 1'b0;
    in_data_i  = '0;
    rst_ni     = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: idle behavior, clamps, duration bands, restart and reload while playing
    send_word(cmd_word(wsp_pkg::FUNC_TICK));
    send_word(cmd_word(wsp_pkg::FUNC_START));
    send_word(cmd_word(wsp_pkg::FUNC_TICK));
    send_word(load_word(1'b1, 8'd0, 16'd0, 16'd0));
    send_word(load_word(1'b0, 8'd255, 16'hffff, 16'd1));
    send_word(load_word(1'b0, 8'd100, 16'd100, 16'd2));
    send_word(load_word(1'b0, 8'd101, 16'd101, 16'd1));
    send_word(load_word(1'b0, 8'd200, 16'd1, 16'd1));
    send_word(load_word(1'b0, 8'd201, 16'd99, 16'd1));
    send_word(cmd_word(wsp_pkg::FUNC_START));
    send_word(cmd_word(wsp_pkg::FUNC_START));
    send_ticks(6);
    send_word(load_word(1'b1, 8'd50, 16'd7, 16'hffff));
    send_ticks(2);
    send_word(cmd_word(wsp_pkg::FUNC_STOP));
    send_word(cmd_word(wsp_pkg::FUNC_TICK));
    send_word(load_word(1'b0, 8'd9, 16'd240, 16'd3));
    send_word(cmd_word(wsp_pkg::FUNC_START));
    send_word(cmd_word(wsp_pkg::FUNC_TICK));

    // fill the table past its depth, then play once around it
    send_word(load_word(1'b1, 8'($urandom_range(0, 100)), 16'($urandom), 16'd1));
    repeat (65)
      send_word(load_word(1'b0, 8'($urandom_range(0, 100)), 16'($urandom),
                          16'($urandom_range(0, 1))));
    send_word(cmd_word(wsp_pkg::FUNC_START));
    send_ticks(70);
    send_word(cmd_word(wsp_pkg::FUNC_STOP));

    while (words_sent < 400) begin
      if ($urandom_range(0, 4) != 0) begin
        play_segment_run($urandom_range(1, 6), $urandom_range(4, 30), $urandom_range(0, 1));
      end else begin
        repeat ($urandom_range(1, 8)) send_word(cmd_word(2'($urandom)));
      end
    end
    in_valid_i <= 1'b0;

    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/wsp_pkg.sv
hw/rtl/wsp_ctrl.sv
hw/rtl/wsp_dpath.sv
hw/rtl/waveform_segment_player_unit.sv
dv/waveform_segment_player_unit_tb.sv
